FILE: rtl/jits_pkg.sv
// shared types and constants for the joint impedance torque step
// register indexes, reset values, stage enables and stage payloads
// no dependencies
package jits_pkg;

   localparam int JOINT_COUNT_DEF = 7;
   localparam int JOINT_IDX_W     = 3;
   localparam int DATA_W          = 16;
   localparam int LIM_W           = 15;
   localparam int CSR_DATA_W      = 64;
   localparam int GAIN_HIGH_W     = 48;
   localparam int PROD_W          = 34;
   localparam int TAU_W           = 28;
   localparam int CMD_W           = 17;

   localparam logic [63:0] STIFF_LOW_RST  = 64'h2580_2580_2580_2580;
   localparam logic [47:0] STIFF_HIGH_RST = 48'h0320_0960_0FA0;
   localparam logic [63:0] DAMP_LOW_RST   = 64'h0320_0320_0320_0320;
   localparam logic [47:0] DAMP_HIGH_RST  = 48'h00F0_0190_01E0;
   localparam logic [15:0] WEIGHT_RST     = 16'd64881;
   localparam logic [14:0] STEP_RST       = 15'd256;
   localparam logic [14:0] LIMIT_RST      = 15'd15360;

   typedef enum logic [2:0] {
      CSR_STIFF_LOW  = 3'd0,
      CSR_STIFF_HIGH = 3'd1,
      CSR_DAMP_LOW   = 3'd2,
      CSR_DAMP_HIGH  = 3'd3,
      CSR_WEIGHT     = 3'd4,
      CSR_STEP       = 3'd5,
      CSR_LIMIT      = 3'd6
   } csr_index_type;

   // per-stage load enables and the filter state write strobe
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
      logic fv_write;
   } stage_en_type;

   typedef struct packed {
      logic [JOINT_IDX_W-1:0]   joint;
      logic signed [DATA_W-1:0] fvel;
      logic signed [PROD_W-1:0] kq;
      logic signed [DATA_W-1:0] dvel;
      logic [DATA_W-1:0]        d_gain;
      logic signed [DATA_W-1:0] cor;
      logic signed [DATA_W-1:0] last;
   } s2_type;

   typedef struct packed {
      logic [JOINT_IDX_W-1:0]   joint;
      logic signed [TAU_W-1:0]  tau;
      logic signed [DATA_W-1:0] last;
   } s4_type;

endpackage

FILE: rtl/jits_filter_stage.sv
// velocity low-pass state and first pipeline stage (filter update, stiffness term)
// depends on jits_pkg
module jits_filter_stage
   import jits_pkg::*;
#(
   parameter int JOINT_COUNT = JOINT_COUNT_DEF,
   parameter int JOINT_W     = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  stage_en_type             en,
   input  logic [JOINT_IDX_W-1:0]   joint,
   input  logic                     restart,
   input  logic signed [DATA_W-1:0] mpos,
   input  logic signed [DATA_W-1:0] mvel,
   input  logic signed [DATA_W-1:0] dpos,
   input  logic signed [DATA_W-1:0] dvel,
   input  logic signed [DATA_W-1:0] cor,
   input  logic signed [DATA_W-1:0] last,
   input  logic [DATA_W-1:0]        k_gain,
   input  logic [DATA_W-1:0]        d_gain,
   input  logic [DATA_W-1:0]        weight,
   output s2_type                   s2_ff
);

   logic signed [DATA_W-1:0] fv_ff [JOINT_COUNT];
   logic signed [DATA_W-1:0] f_old;
   logic signed [DATA_W:0]   dv;
   logic signed [DATA_W:0]   qe;
   logic signed [PROD_W-1:0] wprod;
   logic signed [PROD_W-1:0] wround;
   logic signed [DATA_W+1:0] fsum;
   logic signed [DATA_W-1:0] fnew;
   logic signed [PROD_W-1:0] kq;
   s2_type                   s2_in;

   always_comb begin
      // restart seeds the filter, which then leaves the sample unchanged
      f_old  = restart ? mvel : fv_ff[joint[JOINT_W-1:0]];
      dv     = $signed({mvel[DATA_W-1], mvel}) - $signed({f_old[DATA_W-1], f_old});
      wprod  = $signed({1'b0, weight}) * dv;
      wround = wprod + $signed(PROD_W'(32768));
      // f' = f + floor((w*(v-f) + 2^15) / 2^16)
      fsum   = $signed({{2{f_old[DATA_W-1]}}, f_old}) + $signed(wround[PROD_W-1:16]);
      fnew   = fsum[DATA_W-1:0];
      qe     = $signed({dpos[DATA_W-1], dpos}) - $signed({mpos[DATA_W-1], mpos});
      kq     = $signed({1'b0, k_gain}) * qe;

      s2_in.joint  = joint;
      s2_in.fvel   = fnew;
      s2_in.kq     = kq;
      s2_in.dvel   = dvel;
      s2_in.d_gain = d_gain;
      s2_in.cor    = cor;
      s2_in.last   = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < JOINT_COUNT; i++) begin
            fv_ff[i] <= '0;
         end
      end else if (en.fv_write) begin
         fv_ff[joint[JOINT_W-1:0]] <= fnew;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         s2_ff <= s2_in;
      end
   end

endmodule

FILE: rtl/jits_pd_stage.sv
// damping product and pd torque sum stages
// depends on jits_pkg
module jits_pd_stage
   import jits_pkg::*;
(
   input  logic         clock,
   input  stage_en_type en,
   input  s2_type       s2,
   output s4_type       s4_ff
);

   logic [JOINT_IDX_W-1:0]   joint3_ff;
   logic signed [PROD_W-1:0] kq3_ff;
   logic signed [PROD_W-1:0] dve3_ff;
   logic signed [DATA_W-1:0] cor3_ff;
   logic signed [DATA_W-1:0] last3_ff;
   logic signed [DATA_W:0]   ve;
   logic signed [PROD_W-1:0] dve3_in;
   logic signed [PROD_W:0]   pd;
   s4_type                   s4_in;

   always_comb begin
      ve      = $signed({s2.dvel[DATA_W-1], s2.dvel}) - $signed({s2.fvel[DATA_W-1], s2.fvel});
      dve3_in = $signed({1'b0, s2.d_gain}) * ve;
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         joint3_ff <= s2.joint;
         kq3_ff    <= s2.kq;
         dve3_ff   <= dve3_in;
         cor3_ff   <= s2.cor;
         last3_ff  <= s2.last;
      end
   end

   always_comb begin
      // round to Q8.8 with floor after adding half an lsb
      pd          = $signed({kq3_ff[PROD_W-1], kq3_ff}) + $signed({dve3_ff[PROD_W-1], dve3_ff})
                    + $signed((PROD_W+1)'(128));
      s4_in.joint = joint3_ff;
      s4_in.tau   = $signed({pd[PROD_W], pd[PROD_W:8]})
                    + $signed({{(TAU_W-DATA_W){cor3_ff[DATA_W-1]}}, cor3_ff});
      s4_in.last  = last3_ff;
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         s4_ff <= s4_in;
      end
   end

endmodule

FILE: rtl/jits_limit_stage.sv
// rate limit against last desired torque, then absolute clamp into the output register
// depends on jits_pkg
module jits_limit_stage
   import jits_pkg::*;
(
   input  logic                     clock,
   input  stage_en_type             en,
   input  s4_type                   s4,
   input  logic [LIM_W-1:0]         max_step,
   input  logic [LIM_W-1:0]         limit,
   output logic [JOINT_IDX_W-1:0]   joint_ff,
   output logic signed [DATA_W-1:0] torque_ff,
   output logic                     rate_ff,
   output logic                     clamp_ff
);

   localparam int DIFF_W = TAU_W + 1;

   logic [JOINT_IDX_W-1:0]   joint5_ff;
   logic signed [CMD_W-1:0]  u5_ff;
   logic                     rate5_ff;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] step_pos;
   logic signed [DIFF_W-1:0] step_neg;
   logic signed [DIFF_W-1:0] diff_lim;
   logic signed [CMD_W-1:0]  u5_in;
   logic                     rate5_in;
   logic signed [CMD_W-1:0]  lim_pos;
   logic signed [CMD_W-1:0]  lim_neg;
   logic signed [DATA_W-1:0] torque_in;
   logic                     clamp_in;

   always_comb begin
      diff     = $signed({s4.tau[TAU_W-1], s4.tau})
                 - $signed({{(DIFF_W-DATA_W){s4.last[DATA_W-1]}}, s4.last});
      step_pos = $signed({{(DIFF_W-LIM_W){1'b0}}, max_step});
      step_neg = -step_pos;
      rate5_in = 1'b0;
      diff_lim = diff;
      if (diff > step_pos) begin
         diff_lim = step_pos;
         rate5_in = 1'b1;
      end else if (diff < step_neg) begin
         diff_lim = step_neg;
         rate5_in = 1'b1;
      end
      u5_in = $signed(diff_lim[CMD_W-1:0]) + $signed({s4.last[DATA_W-1], s4.last});
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         joint5_ff <= s4.joint;
         u5_ff     <= u5_in;
         rate5_ff  <= rate5_in;
      end
   end

   always_comb begin
      lim_pos   = $signed({2'b00, limit});
      lim_neg   = -lim_pos;
      clamp_in  = 1'b0;
      torque_in = u5_ff[DATA_W-1:0];
      if (u5_ff > lim_pos) begin
         torque_in = lim_pos[DATA_W-1:0];
         clamp_in  = 1'b1;
      end else if (u5_ff < lim_neg) begin
         torque_in = lim_neg[DATA_W-1:0];
         clamp_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s6) begin
         joint_ff  <= joint5_ff;
         torque_ff <= torque_in;
         rate_ff   <= rate5_ff;
         clamp_ff  <= clamp_in;
      end
   end

endmodule

FILE: rtl/joint_impedance_torque_step.sv
// rsp_valid rises once a request has passed the input register, then the filter and
// stiffness product, damping product, pd sum, rate limit and clamp into the output register
// throughput: one request per cycle unless the output stalls; empty stages then close up
// reset: empties the pipeline, clears every joint's filtered velocity, loads default gains
// and limits; requests for a joint index at or above JOINT_COUNT are taken and dropped
module joint_impedance_torque_step
   import jits_pkg::*;
#(
   parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [JOINT_IDX_W-1:0]        req_joint_index,
   input  logic                          req_restart,
   input  logic signed [DATA_W-1:0]      req_measured_position,
   input  logic signed [DATA_W-1:0]      req_measured_velocity,
   input  logic signed [DATA_W-1:0]      req_desired_position,
   input  logic signed [DATA_W-1:0]      req_desired_velocity,
   input  logic signed [DATA_W-1:0]      req_coriolis_torque,
   input  logic signed [DATA_W-1:0]      req_last_desired_torque,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [JOINT_IDX_W-1:0]        rsp_joint_out,
   output logic signed [DATA_W-1:0]      rsp_torque_command,
   output logic                          rsp_rate_limited,
   output logic                          rsp_limit_clamped,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int JOINT_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
   localparam int GVEC_W  = 2 * CSR_DATA_W;

   logic [CSR_DATA_W-1:0]  stiff_low_ff;
   logic [GAIN_HIGH_W-1:0] stiff_high_ff;
   logic [CSR_DATA_W-1:0]  damp_low_ff;
   logic [GAIN_HIGH_W-1:0] damp_high_ff;
   logic [DATA_W-1:0]      weight_ff;
   logic [LIM_W-1:0]       step_ff;
   logic [LIM_W-1:0]       limit_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
   logic req_fire;
   logic joint_ok;
   stage_en_type en;

   logic [JOINT_IDX_W-1:0]   joint1_ff;
   logic                     restart1_ff;
   logic signed [DATA_W-1:0] mpos1_ff, mvel1_ff, dpos1_ff, dvel1_ff, cor1_ff, last1_ff;
   logic [GVEC_W-1:0]        k_vec, d_vec;
   logic [DATA_W-1:0]        k_gain, d_gain;

   s2_type s2;
   s4_type s4;

   // configuration, to be written while idle; the block itself does not enforce this
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_low_ff  <= STIFF_LOW_RST;
         stiff_high_ff <= STIFF_HIGH_RST;
         damp_low_ff   <= DAMP_LOW_RST;
         damp_high_ff  <= DAMP_HIGH_RST;
         weight_ff     <= WEIGHT_RST;
         step_ff       <= STEP_RST;
         limit_ff      <= LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STIFF_LOW:  stiff_low_ff  <= csr_wdata;
            CSR_STIFF_HIGH: stiff_high_ff <= csr_wdata[GAIN_HIGH_W-1:0];
            CSR_DAMP_LOW:   damp_low_ff   <= csr_wdata;
            CSR_DAMP_HIGH:  damp_high_ff  <= csr_wdata[GAIN_HIGH_W-1:0];
            CSR_WEIGHT:     weight_ff     <= csr_wdata[DATA_W-1:0];
            CSR_STEP:       step_ff       <= csr_wdata[LIM_W-1:0];
            CSR_LIMIT:      limit_ff      <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // a stage takes new data when it is empty or the next one takes its data
   assign rdy6      = !v6_ff || rsp_ready;
   assign rdy5      = !v5_ff || rdy6;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign req_fire  = req_valid && req_ready;
   assign joint_ok  = {1'b0, req_joint_index} < (JOINT_IDX_W+1)'(JOINT_COUNT);

   always_comb begin
      en.s2       = rdy2;
      en.s3       = rdy3;
      en.s4       = rdy4;
      en.s5       = rdy5;
      en.s6       = rdy6;
      en.fv_write = v1_ff && rdy2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_fire && joint_ok;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         joint1_ff   <= req_joint_index;
         restart1_ff <= req_restart;
         mpos1_ff    <= req_measured_position;
         mvel1_ff    <= req_measured_velocity;
         dpos1_ff    <= req_desired_position;
         dvel1_ff    <= req_desired_velocity;
         cor1_ff     <= req_coriolis_torque;
         last1_ff    <= req_last_desired_torque;
      end
   end

   // joint 7 falls on the absent top field and reads a zero gain
   assign k_vec  = {{(GVEC_W-CSR_DATA_W-GAIN_HIGH_W){1'b0}}, stiff_high_ff, stiff_low_ff};
   assign d_vec  = {{(GVEC_W-CSR_DATA_W-GAIN_HIGH_W){1'b0}}, damp_high_ff, damp_low_ff};
   assign k_gain = k_vec[{joint1_ff, 4'b0000} +: DATA_W];
   assign d_gain = d_vec[{joint1_ff, 4'b0000} +: DATA_W];

   jits_filter_stage #(
      .JOINT_COUNT (JOINT_COUNT),
      .JOINT_W     (JOINT_W)
   ) u_filter (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .joint   (joint1_ff),
      .restart (restart1_ff),
      .mpos    (mpos1_ff),
      .mvel    (mvel1_ff),
      .dpos    (dpos1_ff),
      .dvel    (dvel1_ff),
      .cor     (cor1_ff),
      .last    (last1_ff),
      .k_gain  (k_gain),
      .d_gain  (d_gain),
      .weight  (weight_ff),
      .s2_ff   (s2)
   );

   jits_pd_stage u_pd (
      .clock (clock),
      .en    (en),
      .s2    (s2),
      .s4_ff (s4)
   );

   jits_limit_stage u_limit (
      .clock     (clock),
      .en        (en),
      .s4        (s4),
      .max_step  (step_ff),
      .limit     (limit_ff),
      .joint_ff  (rsp_joint_out),
      .torque_ff (rsp_torque_command),
      .rate_ff   (rsp_rate_limited),
      .clamp_ff  (rsp_limit_clamped)
   );

   assign rsp_valid = v6_ff;

   logic signed [DATA_W:0] tq_ext;
   logic signed [DATA_W:0] lim_ext;
   assign tq_ext  = $signed({rsp_torque_command[DATA_W-1], rsp_torque_command});
   assign lim_ext = $signed({2'b00, limit_ff});

   a_cmd_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (tq_ext <= lim_ext) && (tq_ext >= -lim_ext))
      else $error("torque command outside absolute limit");

   a_clamp_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_limit_clamped |-> (tq_ext == lim_ext) || (tq_ext == -lim_ext))
      else $error("clamped command not at the limit");

   a_drop_bad_joint: assert property (@(posedge clock) disable iff (reset)
      req_fire && !joint_ok |=> !v1_ff)
      else $error("request for absent joint entered the pipeline");

   a_state_write: assert property (@(posedge clock) disable iff (reset)
      en.fv_write |-> {1'b0, joint1_ff} < (JOINT_IDX_W+1)'(JOINT_COUNT))
      else $error("filter state write for absent joint");

endmodule
